// ===== rtl/core/tkheap_pkg.sv =====
package tkheap_pkg;

    // Field widths
    localparam int DIST_W      = 32;
    localparam int ID_W        = 32;
    localparam int KEY_W       = DIST_W + ID_W;
    localparam int EF_W        = 8;
    localparam int COUNT_OUT_W = 9;

    // Search breadth after reset
    localparam logic [EF_W-1:0] EF_RESET = 8'd16;

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    // Flipping the sign bit makes unsigned key order equal (distance, id) order
    localparam logic [DIST_W-1:0] DIST_BIAS = 32'h8000_0000;

    typedef logic [KEY_W-1:0] heap_key_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POP_RD,
        ST_POP_LD,
        ST_SD_RDL,
        ST_SD_RDR,
        ST_SD_CMP,
        ST_SU_RD,
        ST_SU_CMP,
        ST_FIN,
        ST_DONE
    } heap_state_t;

endpackage

// ===== rtl/core/bounded_topk_discard_heap_core.sv =====
// Bounded (distance, id) max-heap keeping the closest candidates; one two-port RAM, one comparator.
// A pop error, a pop of the last entry or a rejected insert goes straight to the done state; an insert
// below the limit sifts up, a replace sifts down from the root, and a pop first moves the last entry there.
// Throughput: the next start is taken the cycle after done; the receiver cannot stall results.
// rst_n (async, active low) empties the heap and sets the search breadth to 16; RAM is not cleared.
module bounded_topk_discard_heap_core #(
    parameter int CAPACITY = 256
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // command channel
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   op,
    input  logic signed [tkheap_pkg::DIST_W-1:0]   distance,
    input  logic        [tkheap_pkg::ID_W-1:0]     node_id,
    // search breadth write channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic        [tkheap_pkg::EF_W-1:0]     cfg_data,
    // result strobe
    output logic                                   done,
    output logic signed [tkheap_pkg::DIST_W-1:0]   top_distance,
    output logic        [tkheap_pkg::ID_W-1:0]     top_id,
    output logic                                   is_empty,
    output logic        [tkheap_pkg::COUNT_OUT_W-1:0] entry_count,
    output logic                                   pop_error
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = (CW > tkheap_pkg::EF_W + 1) ? CW : tkheap_pkg::EF_W + 1;
    localparam int XW = AW + 2;

    // Heap RAM: one write and one registered read per cycle
    tkheap_pkg::heap_key_t heap_mem [CAPACITY];
    tkheap_pkg::heap_key_t rd_data_reg;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    tkheap_pkg::heap_key_t wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            heap_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= heap_mem[rd_addr];
        end
    end

    // Control and datapath registers
    tkheap_pkg::heap_state_t state_reg, state_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [tkheap_pkg::EF_W-1:0] ef_reg;
    logic                       err_reg, err_next;
    tkheap_pkg::heap_key_t      root_reg;
    tkheap_pkg::heap_key_t      cur_reg, cur_next;
    logic [AW-1:0]              pos_reg, pos_next;
    tkheap_pkg::heap_key_t      best_reg, best_next;
    logic [AW-1:0]              best_idx_reg, best_idx_next;
    logic                       best_child_reg, best_child_next;
    logic                       has_right_reg, has_right_next;

    // Incoming key and limit
    tkheap_pkg::heap_key_t cand_key;
    logic [LW-1:0]         two_ef;
    logic [LW-1:0]         limit;
    logic                  below_limit;
    logic                  replace_ok;
    logic                  accept;

    assign cand_key    = {distance ^ tkheap_pkg::DIST_BIAS, node_id};
    assign two_ef      = LW'({ef_reg, 1'b0});
    assign limit       = (two_ef > LW'(CAPACITY)) ? LW'(CAPACITY) : two_ef;
    assign below_limit = LW'(count_reg) < limit;
    assign replace_ok  = (count_reg != '0) &&
                         (root_reg[tkheap_pkg::KEY_W-1 -: tkheap_pkg::DIST_W] >
                          cand_key[tkheap_pkg::KEY_W-1 -: tkheap_pkg::DIST_W]);
    assign accept      = start && !busy;

    // Tree navigation
    logic [XW-1:0] left_idx;
    logic [XW-1:0] right_idx;
    logic [XW-1:0] n_ext;
    logic [AW-1:0] parent_idx;

    assign left_idx   = {1'b0, pos_reg, 1'b1};
    assign right_idx  = left_idx + XW'(1);
    assign n_ext      = XW'(count_reg);
    assign parent_idx = (pos_reg - AW'(1)) >> 1;

    // Shared key comparator
    tkheap_pkg::heap_key_t cmp_a;
    tkheap_pkg::heap_key_t cmp_b;
    logic                  cmp_gt;

    always_comb
    begin
        cmp_a = rd_data_reg;
        cmp_b = cur_reg;
        case (state_reg)
            tkheap_pkg::ST_SD_CMP:
            begin
                cmp_a = rd_data_reg;
                cmp_b = best_reg;
            end
            tkheap_pkg::ST_SU_CMP:
            begin
                cmp_a = cur_reg;
                cmp_b = rd_data_reg;
            end
            default:
            begin
                cmp_a = rd_data_reg;
                cmp_b = cur_reg;
            end
        endcase
    end

    assign cmp_gt = cmp_a > cmp_b;

    // Winner of the two-child check
    logic right_wins;
    logic child_wins;
    assign right_wins = has_right_reg && cmp_gt;
    assign child_wins = right_wins || best_child_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tkheap_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (op == tkheap_pkg::OP_INSERT)
                    begin
                        if (below_limit)
                        begin
                            state_next = (count_reg == '0) ? tkheap_pkg::ST_FIN
                                                           : tkheap_pkg::ST_SU_RD;
                        end
                        else if (replace_ok)
                        begin
                            state_next = tkheap_pkg::ST_SD_RDL;
                        end
                        else
                        begin
                            state_next = tkheap_pkg::ST_DONE;
                        end
                    end
                    else
                    begin
                        state_next = (count_reg > CW'(1)) ? tkheap_pkg::ST_POP_RD
                                                          : tkheap_pkg::ST_DONE;
                    end
                end
            end
            tkheap_pkg::ST_POP_RD: state_next = tkheap_pkg::ST_POP_LD;
            tkheap_pkg::ST_POP_LD: state_next = tkheap_pkg::ST_SD_RDL;
            tkheap_pkg::ST_SD_RDL:
            begin
                state_next = (left_idx < n_ext) ? tkheap_pkg::ST_SD_RDR
                                                : tkheap_pkg::ST_FIN;
            end
            tkheap_pkg::ST_SD_RDR: state_next = tkheap_pkg::ST_SD_CMP;
            tkheap_pkg::ST_SD_CMP:
            begin
                state_next = child_wins ? tkheap_pkg::ST_SD_RDL : tkheap_pkg::ST_FIN;
            end
            tkheap_pkg::ST_SU_RD: state_next = tkheap_pkg::ST_SU_CMP;
            tkheap_pkg::ST_SU_CMP:
            begin
                if (cmp_gt && (parent_idx != '0))
                begin
                    state_next = tkheap_pkg::ST_SU_RD;
                end
                else
                begin
                    state_next = tkheap_pkg::ST_FIN;
                end
            end
            tkheap_pkg::ST_FIN:  state_next = tkheap_pkg::ST_DONE;
            tkheap_pkg::ST_DONE: state_next = tkheap_pkg::ST_IDLE;
            default:             state_next = tkheap_pkg::ST_IDLE;
        endcase
    end

    // FSM outputs: RAM control
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = pos_reg;
        wr_data = cur_reg;
        unique case (state_reg)
            tkheap_pkg::ST_POP_RD:
            begin
                // last entry moves to the root
                rd_en   = 1'b1;
                rd_addr = count_reg[AW-1:0];
            end
            tkheap_pkg::ST_SD_RDL:
            begin
                rd_en   = left_idx < n_ext;
                rd_addr = left_idx[AW-1:0];
            end
            tkheap_pkg::ST_SD_RDR:
            begin
                rd_en   = right_idx < n_ext;
                rd_addr = right_idx[AW-1:0];
            end
            tkheap_pkg::ST_SD_CMP:
            begin
                // larger child moves up into the hole
                wr_en   = child_wins;
                wr_data = right_wins ? rd_data_reg : best_reg;
            end
            tkheap_pkg::ST_SU_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = parent_idx;
            end
            tkheap_pkg::ST_SU_CMP:
            begin
                // parent moves down into the hole
                wr_en   = cmp_gt;
                wr_data = rd_data_reg;
            end
            tkheap_pkg::ST_FIN:
            begin
                wr_en   = 1'b1;
                wr_data = cur_reg;
            end
            default:
            begin
                rd_en = 1'b0;
                wr_en = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        count_next      = count_reg;
        err_next        = err_reg;
        cur_next        = cur_reg;
        pos_next        = pos_reg;
        best_next       = best_reg;
        best_idx_next   = best_idx_reg;
        best_child_next = best_child_reg;
        has_right_next  = has_right_reg;
        case (state_reg)
            tkheap_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    err_next = 1'b0;
                    if (op == tkheap_pkg::OP_INSERT)
                    begin
                        cur_next = cand_key;
                        if (below_limit)
                        begin
                            pos_next   = count_reg[AW-1:0];
                            count_next = count_reg + CW'(1);
                        end
                        else
                        begin
                            pos_next = '0;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                        pos_next   = '0;
                    end
                end
            end
            tkheap_pkg::ST_POP_LD:
            begin
                cur_next = rd_data_reg;
            end
            tkheap_pkg::ST_SD_RDR:
            begin
                // left child against the moving key
                has_right_next = right_idx < n_ext;
                if (cmp_gt)
                begin
                    best_next       = rd_data_reg;
                    best_idx_next   = left_idx[AW-1:0];
                    best_child_next = 1'b1;
                end
                else
                begin
                    best_next       = cur_reg;
                    best_idx_next   = pos_reg;
                    best_child_next = 1'b0;
                end
            end
            tkheap_pkg::ST_SD_CMP:
            begin
                if (right_wins)
                begin
                    pos_next = right_idx[AW-1:0];
                end
                else if (best_child_reg)
                begin
                    pos_next = best_idx_reg;
                end
            end
            tkheap_pkg::ST_SU_CMP:
            begin
                if (cmp_gt)
                begin
                    pos_next = parent_idx;
                end
            end
            default:
            begin
                cur_next = cur_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tkheap_pkg::ST_IDLE;
            count_reg <= '0;
            ef_reg    <= tkheap_pkg::EF_RESET;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            err_reg   <= err_next;
            if (cfg_valid && cfg_ready)
            begin
                ef_reg <= cfg_data;
            end
        end
    end

    // Payload registers; root copy tracks every write to slot zero
    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        pos_reg        <= pos_next;
        best_reg       <= best_next;
        best_idx_reg   <= best_idx_next;
        best_child_reg <= best_child_next;
        has_right_reg  <= has_right_next;
        if (wr_en && (wr_addr == '0))
        begin
            root_reg <= wr_data;
        end
    end

    // Ports
    assign busy         = state_reg != tkheap_pkg::ST_IDLE;
    assign cfg_ready    = 1'b1;
    assign done         = state_reg == tkheap_pkg::ST_DONE;
    assign is_empty     = count_reg == '0;
    assign top_distance = is_empty ? '0
                        : root_reg[tkheap_pkg::KEY_W-1 -: tkheap_pkg::DIST_W] ^
                          tkheap_pkg::DIST_BIAS;
    assign top_id       = is_empty ? '0 : root_reg[tkheap_pkg::ID_W-1:0];
    assign entry_count  = tkheap_pkg::COUNT_OUT_W'(count_reg);
    assign pop_error    = err_reg;

endmodule

// ===== bench/tb_bounded_topk_discard_heap_core.sv =====
`timescale 1ns / 100ps

module tb_bounded_topk_discard_heap_core;

    localparam int HEAP_DEPTH  = 256;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 40;
    localparam int PRINT_LIMIT = 200;

    // One observed or predicted heap report
    typedef struct {
        logic signed [tkheap_pkg::DIST_W-1:0]  top_dist;
        logic [tkheap_pkg::ID_W-1:0]           id;
        logic                                  empty;
        logic [tkheap_pkg::COUNT_OUT_W-1:0]    count;
        logic                                  err;
    } heap_report_t;

    logic                                  clk;
    logic                                  rst_n        = 1'b0;
    logic                                  start        = 1'b0;
    logic                                  busy;
    logic                                  op           = tkheap_pkg::OP_INSERT;
    logic signed [tkheap_pkg::DIST_W-1:0]  distance     = '0;
    logic [tkheap_pkg::ID_W-1:0]           node_id      = '0;
    logic                                  cfg_valid    = 1'b0;
    logic                                  cfg_ready;
    logic [tkheap_pkg::EF_W-1:0]           cfg_data     = '0;
    logic                                  done;
    logic signed [tkheap_pkg::DIST_W-1:0]  top_distance;
    logic [tkheap_pkg::ID_W-1:0]           top_id;
    logic                                  is_empty;
    logic [tkheap_pkg::COUNT_OUT_W-1:0]    entry_count;
    logic                                  pop_error;

    // Predictor state: shadow max-heap of biased keys
    tkheap_pkg::heap_key_t         shadow_heap [0:HEAP_DEPTH-1];
    int                            shadow_count = 0;
    int                            shadow_ef    = tkheap_pkg::EF_RESET;

    heap_report_t                  pending_reports [$];
    int                            mismatch_count  = 0;
    int                            sender_idle_pct = 0;

    bounded_topk_discard_heap_core #(
        .CAPACITY (HEAP_DEPTH)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .distance     (distance),
        .node_id      (node_id),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .done         (done),
        .top_distance (top_distance),
        .top_id       (top_id),
        .is_empty     (is_empty),
        .entry_count  (entry_count),
        .pop_error    (pop_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Shadow heap
    // ---------------------------------------------------------------
    function automatic void heap_swap(int a, int b);
        tkheap_pkg::heap_key_t tmp;
        tmp            = shadow_heap[a];
        shadow_heap[a] = shadow_heap[b];
        shadow_heap[b] = tmp;
    endfunction

    function automatic void heap_sift_up(int pos);
        int parent;
        while (pos > 0)
        begin
            parent = (pos - 1) / 2;
            if (shadow_heap[parent] >= shadow_heap[pos])
                break;
            heap_swap(parent, pos);
            pos = parent;
        end
    endfunction

    function automatic void heap_sift_down(int pos);
        int left;
        int right;
        int largest;
        forever
        begin
            left    = 2 * pos + 1;
            right   = left + 1;
            largest = pos;
            if (left < shadow_count && shadow_heap[left] > shadow_heap[largest])
                largest = left;
            if (right < shadow_count && shadow_heap[right] > shadow_heap[largest])
                largest = right;
            if (largest == pos)
                break;
            heap_swap(largest, pos);
            pos = largest;
        end
    endfunction

    function automatic void heap_drop_root();
        if (shadow_count == 0)
            return;
        shadow_count--;
        if (shadow_count > 0)
        begin
            shadow_heap[0] = shadow_heap[shadow_count];
            heap_sift_down(0);
        end
    endfunction

    function automatic void heap_push(tkheap_pkg::heap_key_t key);
        if (shadow_count >= HEAP_DEPTH)
            return;
        shadow_heap[shadow_count] = key;
        shadow_count++;
        heap_sift_up(shadow_count - 1);
    endfunction

    // Applies one command to the shadow heap, returns the report it should produce
    function automatic heap_report_t predict_heap_step(
        logic cmd,
        logic signed [tkheap_pkg::DIST_W-1:0] cand_dist,
        logic [tkheap_pkg::ID_W-1:0] id);
        heap_report_t                         rep;
        int                                   limit;
        tkheap_pkg::heap_key_t                key;
        logic signed [tkheap_pkg::DIST_W-1:0] root_dist;
        key     = {cand_dist ^ tkheap_pkg::DIST_BIAS, id};
        limit   = 2 * shadow_ef;
        rep.err = 1'b0;
        if (limit > HEAP_DEPTH)
            limit = HEAP_DEPTH;
        if (cmd == tkheap_pkg::OP_INSERT)
        begin
            if (shadow_count >= limit)
            begin
                // at the limit only a strictly closer candidate displaces the root
                if (shadow_count > 0)
                begin
                    root_dist = shadow_heap[0][tkheap_pkg::KEY_W-1 -: tkheap_pkg::DIST_W] ^
                                tkheap_pkg::DIST_BIAS;
                    if (root_dist > cand_dist)
                    begin
                        heap_drop_root();
                        heap_push(key);
                    end
                end
            end
            else
            begin
                heap_push(key);
            end
        end
        else if (shadow_count == 0)
        begin
            rep.err = 1'b1;
        end
        else
        begin
            heap_drop_root();
        end
        if (shadow_count > 0)
        begin
            rep.top_dist = shadow_heap[0][tkheap_pkg::KEY_W-1 -: tkheap_pkg::DIST_W] ^
                           tkheap_pkg::DIST_BIAS;
            rep.id       = shadow_heap[0][tkheap_pkg::ID_W-1:0];
            rep.empty    = 1'b0;
        end
        else
        begin
            rep.top_dist = '0;
            rep.id       = '0;
            rep.empty    = 1'b1;
        end
        rep.count = shadow_count[tkheap_pkg::COUNT_OUT_W-1:0];
        return rep;
    endfunction

    // ---------------------------------------------------------------
    // Driving
    // ---------------------------------------------------------------
    // Sends one command; returns just after the edge that accepted it
    task automatic send_command(logic cmd, logic signed [tkheap_pkg::DIST_W-1:0] cand_dist,
                                logic [tkheap_pkg::ID_W-1:0] id);
        if ($urandom_range(0, 99) < sender_idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < sender_idle_pct);
        end
        start    <= 1'b1;
        op       <= cmd;
        distance <= cand_dist;
        node_id  <= id;
        do
            @(posedge clk);
        while (busy);
        pending_reports.push_back(predict_heap_step(cmd, cand_dist, id));
    endtask

    // Sender holds off until every pending report has come back
    task automatic wait_drained();
        start <= 1'b0;
        while (pending_reports.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_breadth(int value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value[tkheap_pkg::EF_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        shadow_ef = value;
        cfg_valid <= 1'b0;
    endtask

    // Mix of tie-prone small values, extremes and full-range values
    function automatic logic signed [tkheap_pkg::DIST_W-1:0] pick_distance();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3)
            return ($urandom_range(0, 6) - 3) * 65536;
        if (sel == 3)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7fff_ffff;
                2:       return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [tkheap_pkg::ID_W-1:0] pick_node_id();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3)
            return $urandom_range(0, 3);
        if (sel == 3)
            return $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
        return $urandom;
    endfunction

    task automatic run_random_commands(int count, int insert_pct);
        logic cmd;
        for (int i = 0; i < count; i++)
        begin
            cmd = ($urandom_range(0, 99) < insert_pct) ? tkheap_pkg::OP_INSERT
                                                        : tkheap_pkg::OP_POP;
            send_command(cmd, pick_distance(), pick_node_id());
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_directed();
        // reset limit, pops on empty and key extremes
        send_command(tkheap_pkg::OP_POP,    32'sh0,           32'h0);
        send_command(tkheap_pkg::OP_INSERT, 32'sh7fff_ffff,   32'hffff_ffff);
        send_command(tkheap_pkg::OP_INSERT, 32'sh8000_0000,   32'h0);
        send_command(tkheap_pkg::OP_INSERT, 32'sh8000_0000,   32'hffff_ffff);
        send_command(tkheap_pkg::OP_INSERT, 32'sh0,           32'h1);
        repeat (4)
            send_command(tkheap_pkg::OP_POP, 32'sh0, 32'h0);
        send_command(tkheap_pkg::OP_POP,    32'sh7fff_ffff,   32'hffff_ffff);
        // limit of two: equal, larger and smaller candidates at the limit
        write_breadth(1);
        send_command(tkheap_pkg::OP_INSERT, 32'sh0005_0000,   32'h7);
        send_command(tkheap_pkg::OP_INSERT, 32'sh0005_0000,   32'h3);
        send_command(tkheap_pkg::OP_INSERT, 32'sh0005_0000,   32'h64);
        send_command(tkheap_pkg::OP_INSERT, 32'sh0006_0000,   32'h1);
        send_command(tkheap_pkg::OP_INSERT, 32'shffff_0000,   32'h9);
        // zero limit: a closer candidate still replaces the root, then empty heap ignores inserts
        write_breadth(0);
        send_command(tkheap_pkg::OP_INSERT, 32'shff9c_0000,   32'h2);
        repeat (3)
            send_command(tkheap_pkg::OP_POP, 32'sh0, 32'h0);
        send_command(tkheap_pkg::OP_INSERT, 32'sh0,           32'h0);
        // largest register value, limit capped at capacity
        write_breadth(255);
        send_command(tkheap_pkg::OP_INSERT, 32'sh7fff_ffff,   32'h0);
        send_command(tkheap_pkg::OP_POP,    32'sh0,           32'h0);
    endtask

    task automatic test_fill_to_capacity();
        write_breadth(128);
        run_random_commands(330, 90);
    endtask

    task automatic test_oversize_limit();
        write_breadth(255);
        run_random_commands(150, 60);
    endtask

    task automatic test_lowered_limit();
        write_breadth(3);
        run_random_commands(100, 45);
        // sender pauses until the block has answered everything
        wait_drained();
        run_random_commands(100, 45);
    endtask

    task automatic test_tight_limit();
        write_breadth(1);
        run_random_commands(150, 60);
    endtask

    task automatic test_mid_limit();
        write_breadth(64);
        run_random_commands(250, 60);
    endtask

    task automatic test_zero_limit();
        write_breadth(0);
        run_random_commands(100, 30);
    endtask

    task automatic test_mixed_limits();
        for (int chunk = 0; chunk < 5; chunk++)
        begin
            write_breadth($urandom_range(1, 128));
            run_random_commands(50, 65);
        end
    endtask

    // ---------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------
    task automatic report_mismatch(string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t ns  MISMATCH  %s", $time, msg);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : check_results
        heap_report_t want;
        if (rst_n && done)
        begin
            if (pending_reports.size() == 0)
            begin
                report_mismatch($sformatf("result with no transaction pending (count %0d)",
                                          entry_count));
            end
            else
            begin
                want = pending_reports.pop_front();
                if (top_distance !== want.top_dist)
                    report_mismatch($sformatf("top_distance %h, expected %h",
                                              top_distance, want.top_dist));
                if (top_id !== want.id)
                    report_mismatch($sformatf("top_id %h, expected %h", top_id, want.id));
                if (is_empty !== want.empty)
                    report_mismatch($sformatf("is_empty %b, expected %b",
                                              is_empty, want.empty));
                if (entry_count !== want.count)
                    report_mismatch($sformatf("entry_count %0d, expected %0d",
                                              entry_count, want.count));
                if (pop_error !== want.err)
                    report_mismatch($sformatf("pop_error %b, expected %b",
                                              pop_error, want.err));
            end
        end
    end

    // Watchdog: cycles without any transaction or result
    initial
    begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial
    begin
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idle_pct = 11;
        test_directed();
        test_fill_to_capacity();
        test_oversize_limit();
        test_lowered_limit();

        sender_idle_pct = 87;
        test_tight_limit();
        test_mid_limit();

        sender_idle_pct = 0;
        test_zero_limit();
        test_mixed_limits();

        wait_drained();
        repeat (DRAIN_WAIT)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
